// File: rtl/smd_pkg.sv
// Shared types and constants of the stack bytecode move decoder.
`default_nettype none

package smd_pkg;

  // Stack geometry
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MOVE_ARGS   = 7;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PUSH_OPCODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_OPCODE = 1'd1;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] PUSH_OPCODE_RST = 8'd0;
  localparam logic [BYTE_W-1:0] MOVE_OPCODE_RST = 8'd1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_AWAIT   = 3'd0,
    ST_PUSHED  = 3'd1,
    ST_FULL    = 3'd2,
    ST_MOVE    = 3'd3,
    ST_NOARGS  = 3'd4,
    ST_UNKNOWN = 3'd5,
    ST_DROPPED = 3'd6
  } smd_status_e;

  // One input beat
  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              program_end;
  } smd_item_t;

  // Configuration registers
  typedef struct packed {
    logic [BYTE_W-1:0] push_opcode;
    logic [BYTE_W-1:0] move_opcode;
  } smd_cfg_t;

  // One result beat
  typedef struct packed {
    smd_status_e        status;
    logic [BYTE_W-1:0]  target_x;
    logic [BYTE_W-1:0]  target_y;
    logic [BYTE_W-1:0]  target_z;
    logic [BYTE_W-1:0]  heading_x;
    logic [BYTE_W-1:0]  heading_y;
    logic [BYTE_W-1:0]  heading_z;
    logic [BYTE_W-1:0]  move_speed;
    logic [LEVEL_W-1:0] stack_level;
  } smd_result_t;

endpackage

`default_nettype wire

// File: rtl/smd_if.sv
// Valid/ready channel interfaces for bytecode input and decode results.
`default_nettype none

interface smd_in_if
  import smd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              program_end;

  modport source (output valid, output code_byte, output program_end, input ready);
  modport sink   (input valid, input code_byte, input program_end, output ready);
endinterface

interface smd_out_if
  import smd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   target_x;
  logic [BYTE_W-1:0]   target_y;
  logic [BYTE_W-1:0]   target_z;
  logic [BYTE_W-1:0]   heading_x;
  logic [BYTE_W-1:0]   heading_y;
  logic [BYTE_W-1:0]   heading_z;
  logic [BYTE_W-1:0]   move_speed;
  logic [LEVEL_W-1:0]  stack_level;

  modport source (
    output valid, output status, output target_x, output target_y, output target_z,
    output heading_x, output heading_y, output heading_z, output move_speed,
    output stack_level, input ready
  );
  modport sink (
    input valid, input status, input target_x, input target_y, input target_z,
    input heading_x, input heading_y, input heading_z, input move_speed,
    input stack_level, output ready
  );
endinterface

`default_nettype wire

// File: rtl/smd_core.sv
// Decode stage: shift-register byte stack, entry count and operand mode.
`default_nettype none

module smd_core
  import smd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire smd_item_t   item_i,
  input  wire smd_cfg_t    cfg_i,
  output smd_result_t      result_o
);

  // Operand mode codes
  localparam logic [1:0] MODE_OPCODE = 2'd0;
  localparam logic [1:0] MODE_PUSH   = 2'd1;
  localparam logic [1:0] MODE_DROP   = 2'd2;

  // Top of stack lives in entry 0
  logic [BYTE_W-1:0] stack_q [STACK_DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [1:0]        mode_q, mode_d;
  logic              push, pop, full;

  assign full = (count_q == CNT_W'(STACK_DEPTH));

  // Decode one byte against the current mode and stack level
  always_comb begin
    result_o = '0;
    result_o.status = ST_AWAIT;
    mode_d  = MODE_OPCODE;
    count_d = count_q;
    push    = 1'b0;
    pop     = 1'b0;
    unique case (mode_q)
      MODE_PUSH: begin
        if (!full) begin
          push    = 1'b1;
          count_d = count_q + CNT_W'(1);
          result_o.status = ST_PUSHED;
        end else begin
          result_o.status = ST_DROPPED;
        end
      end
      MODE_DROP: begin
        result_o.status = ST_DROPPED;
      end
      default: begin
        priority if (item_i.code_byte == cfg_i.push_opcode) begin
          if (full) begin
            result_o.status = ST_FULL;
            mode_d = MODE_DROP;
          end else begin
            result_o.status = ST_AWAIT;
            mode_d = MODE_PUSH;
          end
        end else if (item_i.code_byte == cfg_i.move_opcode) begin
          if (count_q < CNT_W'(MOVE_ARGS)) begin
            result_o.status = ST_NOARGS;
          end else begin
            pop     = 1'b1;
            count_d = count_q - CNT_W'(MOVE_ARGS);
            result_o.status = ST_MOVE;
          end
        end else begin
          result_o.status = ST_UNKNOWN;
        end
      end
    endcase
    // A pending literal never outlives the program
    if (item_i.program_end) begin
      mode_d = MODE_OPCODE;
    end
    if (pop) begin
      result_o.target_x   = stack_q[0];
      result_o.target_y   = stack_q[1];
      result_o.target_z   = stack_q[2];
      result_o.heading_x  = stack_q[3];
      result_o.heading_y  = stack_q[4];
      result_o.heading_z  = stack_q[5];
      result_o.move_speed = stack_q[6];
    end
    result_o.stack_level = LEVEL_W'(32'(count_d));
  end

  // Shift stack entries: down by one on push, up by seven on move
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_entry
    logic [BYTE_W-1:0] push_src, pop_src;
    if (g == 0) begin : g_top
      assign push_src = item_i.code_byte;
    end else begin : g_below
      assign push_src = stack_q[g-1];
    end
    if (g + MOVE_ARGS < STACK_DEPTH) begin : g_pull
      assign pop_src = stack_q[g+MOVE_ARGS];
    end else begin : g_keep
      assign pop_src = stack_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (step_i && push) begin
        stack_q[g] <= push_src;
      end else if (step_i && pop) begin
        stack_q[g] <= pop_src;
      end
    end
  end

  // Advance count and mode on each decoded beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mode_q  <= MODE_OPCODE;
    end else if (step_i) begin
      count_q <= count_d;
      mode_q  <= mode_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != 2'd3)
    else $error("unused operand mode reached");

  a_move_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.status == ST_MOVE |=> count_q == $past(count_q) - CNT_W'(MOVE_ARGS))
    else $error("move did not pop seven entries");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.status == ST_PUSHED |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not grow the stack");

  a_end_clears_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.program_end |=> mode_q == MODE_OPCODE)
    else $error("operand mode survived program end");

endmodule

`default_nettype wire

// File: rtl/stack_bytecode_move_decoder.sv
// Top level of the stack bytecode move decoder.
//
// Bytecode bytes arrive on in_ch (code_byte, program_end) and each beat
// produces exactly one result beat on out_ch: a status code, the seven
// move fields (zero unless a move is emitted) and the stack level after
// the byte. Both channels use valid/ready; a beat moves when both are high.
// The opcode values are set through cfg_we_i/cfg_idx_i/cfg_data_i while
// the block is idle: index 0 is the push opcode, index 1 the move opcode.
// An accepted byte sits in the input register until the decode stage takes
// it, and its result is loaded into the output register, from which it is
// offered. The block takes one byte per cycle while the receiver keeps
// ready high; the single decode stage, with its sixteen-entry shift-register
// stack, sets that rate. When the receiver holds ready low, the output register
// holds its beat, the input register fills and in_ch.ready drops.
// Reset empties the stack, clears the operand mode, drops any held beats
// and returns the opcodes to push 0 and move 1.
`default_nettype none

module stack_bytecode_move_decoder
  import smd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  smd_in_if.sink                    in_ch,
  smd_out_if.source                 out_ch,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i
);

  smd_cfg_t    cfg_q;
  smd_item_t   item_q;
  logic        item_v_q;
  smd_result_t res_d, res_q;
  logic        res_v_q;
  logic        advance, step, in_fire;

  // Pipeline control
  assign advance     = !res_v_q || out_ch.ready;
  assign step        = item_v_q && advance;
  assign in_ch.ready = !item_v_q || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.push_opcode <= PUSH_OPCODE_RST;
      cfg_q.move_opcode <= MOVE_OPCODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PUSH_OPCODE: cfg_q.push_opcode <= cfg_data_i;
        REG_MOVE_OPCODE: cfg_q.move_opcode <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: hold the beat until the decode stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (in_fire) begin
      item_v_q <= 1'b1;
    end else if (step) begin
      item_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.code_byte   <= in_ch.code_byte;
      item_q.program_end <= in_ch.program_end;
    end
  end

  smd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  // Output register: hold the result beat while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (step) begin
      res_v_q <= 1'b1;
    end else if (out_ch.ready) begin
      res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid       = res_v_q;
  assign out_ch.status      = res_q.status;
  assign out_ch.target_x    = res_q.target_x;
  assign out_ch.target_y    = res_q.target_y;
  assign out_ch.target_z    = res_q.target_z;
  assign out_ch.heading_x   = res_q.heading_x;
  assign out_ch.heading_y   = res_q.heading_y;
  assign out_ch.heading_z   = res_q.heading_z;
  assign out_ch.move_speed  = res_q.move_speed;
  assign out_ch.stack_level = res_q.stack_level;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the stack bytecode move decoder.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smd_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_BYTES    = 240;
  localparam int MAX_REPORTS    = 50;
  localparam int IDX_W          = $clog2(STACK_DEPTH);

  // Operand mode of the decoder as tracked by the predictor
  typedef enum logic [1:0] {
    MODE_OPCODE = 2'd0,
    MODE_PUSH   = 2'd1,
    MODE_DROP   = 2'd2
  } operand_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BYTE_W-1:0]    cfg_data_i;

  smd_in_if  in_ch ();
  smd_out_if out_ch ();

  stack_bytecode_move_decoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state: stack, fill level, operand mode and opcodes
  logic [BYTE_W-1:0] model_stack [STACK_DEPTH];
  int unsigned       model_fill;
  operand_mode_e     model_mode;
  logic [BYTE_W-1:0] model_push_op;
  logic [BYTE_W-1:0] model_move_op;

  smd_result_t pending_results [$];
  int          errors     = 0;
  bit          quiet      = 1'b0;
  int          stall_left = 0;

  // Free-running clock
  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Decode one byte against the tracked state and return its result
  function automatic smd_result_t decode_byte(input logic [BYTE_W-1:0] code, input logic last);
    smd_result_t res;
    res = '0;
    case (model_mode)
      MODE_PUSH: begin
        if (model_fill < STACK_DEPTH) begin
          model_stack[IDX_W'(model_fill)] = code;
          model_fill++;
          res.status = ST_PUSHED;
        end else begin
          res.status = ST_DROPPED;
        end
        model_mode = MODE_OPCODE;
      end
      MODE_DROP: begin
        res.status = ST_DROPPED;
        model_mode = MODE_OPCODE;
      end
      default: begin
        // Push wins when both opcodes hold the same value
        if (code == model_push_op) begin
          if (model_fill >= STACK_DEPTH) begin
            res.status = ST_FULL;
            model_mode = MODE_DROP;
          end else begin
            res.status = ST_AWAIT;
            model_mode = MODE_PUSH;
          end
        end else if (code == model_move_op) begin
          if (model_fill < MOVE_ARGS) begin
            res.status = ST_NOARGS;
          end else begin
            res.target_x   = model_stack[IDX_W'(model_fill - 1)];
            res.target_y   = model_stack[IDX_W'(model_fill - 2)];
            res.target_z   = model_stack[IDX_W'(model_fill - 3)];
            res.heading_x  = model_stack[IDX_W'(model_fill - 4)];
            res.heading_y  = model_stack[IDX_W'(model_fill - 5)];
            res.heading_z  = model_stack[IDX_W'(model_fill - 6)];
            res.move_speed = model_stack[IDX_W'(model_fill - 7)];
            model_fill -= MOVE_ARGS;
            res.status = ST_MOVE;
          end
          model_mode = MODE_OPCODE;
        end else begin
          res.status = ST_UNKNOWN;
          model_mode = MODE_OPCODE;
        end
      end
    endcase
    // Last byte of a program drops any pending literal
    if (last) model_mode = MODE_OPCODE;
    res.stack_level = LEVEL_W'(model_fill);
    return res;
  endfunction

  // Drive one byte after a random gap; return at the falling edge after the beat
  task automatic send_byte(input logic [BYTE_W-1:0] code, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.code_byte   = code;
    in_ch.program_end = last;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results = {pending_results, decode_byte(code, last)};
    @(negedge clk_i);
  endtask

  task automatic send_push(input logic [BYTE_W-1:0] literal, input logic last);
    send_byte(model_push_op, 1'b0);
    send_byte(literal, last);
  endtask

  // Hold the input idle until every result is back, then let the pipe settle
  task automatic wait_for_results();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    wait_for_results();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_PUSH_OPCODE) model_push_op = data;
    else model_move_op = data;
  endtask

  task automatic set_opcodes(input logic [BYTE_W-1:0] push_op, input logic [BYTE_W-1:0] move_op);
    write_reg(REG_PUSH_OPCODE, push_op);
    write_reg(REG_MOVE_OPCODE, move_op);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_REPORTS)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Receiver: random stalls on the result channel
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  // Compare every result beat with the oldest prediction
  always @(posedge clk_i) begin
    smd_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no byte pending", int'(out_ch.status), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status != want.status)
          report_mismatch("status", int'(out_ch.status), int'(want.status));
        if (out_ch.target_x != want.target_x)
          report_mismatch("target_x", int'(out_ch.target_x), int'(want.target_x));
        if (out_ch.target_y != want.target_y)
          report_mismatch("target_y", int'(out_ch.target_y), int'(want.target_y));
        if (out_ch.target_z != want.target_z)
          report_mismatch("target_z", int'(out_ch.target_z), int'(want.target_z));
        if (out_ch.heading_x != want.heading_x)
          report_mismatch("heading_x", int'(out_ch.heading_x), int'(want.heading_x));
        if (out_ch.heading_y != want.heading_y)
          report_mismatch("heading_y", int'(out_ch.heading_y), int'(want.heading_y));
        if (out_ch.heading_z != want.heading_z)
          report_mismatch("heading_z", int'(out_ch.heading_z), int'(want.heading_z));
        if (out_ch.move_speed != want.move_speed)
          report_mismatch("move_speed", int'(out_ch.move_speed), int'(want.move_speed));
        if (out_ch.stack_level != want.stack_level)
          report_mismatch("stack_level", int'(out_ch.stack_level), int'(want.stack_level));
      end
    end
  end

  // Stop the run when no beat moves on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    do begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end while (idle_cycles < WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Reset opcodes: empty-stack move, unknown byte, extreme literals, full move,
  // push on the last byte, literal carried on the last byte
  task automatic test_directed();
    logic [BYTE_W-1:0] literals [7];
    literals = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h55, 8'hAA};
    send_byte(model_move_op, 1'b0);
    send_byte(8'hFF, 1'b0);
    foreach (literals[i]) send_push(literals[i], 1'b0);
    send_byte(model_move_op, 1'b0);
    send_byte(model_push_op, 1'b1);
    send_byte(model_move_op, 1'b0);
    send_push(8'hC3, 1'b1);
  endtask

  // Same value for both opcodes: the byte acts as a push
  task automatic test_shared_opcode();
    set_opcodes(8'h5A, 8'h5A);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b0);
  endtask

  // Fill the stack, then push on full, drop literals and pop back down
  task automatic test_stack_overflow(input int reps);
    logic [BYTE_W-1:0] push_op;
    for (int r = 0; r < reps; r++) begin
      push_op = BYTE_W'($urandom_range(255));
      set_opcodes(push_op, push_op ^ BYTE_W'($urandom_range(1, 255)));
      quiet = ($urandom_range(2) == 0);
      while (model_fill < STACK_DEPTH) send_push(BYTE_W'($urandom_range(255)), 1'b0);
      send_push(BYTE_W'($urandom_range(255)), 1'b0);
      send_byte(model_push_op, 1'b1);
      send_push(BYTE_W'($urandom_range(255)), 1'b1);
      send_byte(model_move_op, 1'($urandom_range(1)));
      send_push(BYTE_W'($urandom_range(255)), 1'b0);
      while (model_fill >= MOVE_ARGS) send_byte(model_move_op, 1'b0);
    end
  endtask

  // Well-formed push/move programs with random content, plus noise bytes
  task automatic test_random_programs(input int phases);
    logic [BYTE_W-1:0] push_op;
    logic [BYTE_W-1:0] move_op;
    int                push_w;
    int                sent;
    int                r;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0: begin push_op = 8'hFF; move_op = 8'h00; end
        1: begin push_op = 8'h00; move_op = 8'hFF; end
        2: begin push_op = 8'h80; move_op = 8'h7F; end
        default: begin
          push_op = BYTE_W'($urandom_range(255));
          move_op = push_op ^ BYTE_W'($urandom_range(1, 255));
        end
      endcase
      set_opcodes(push_op, move_op);
      quiet  = (p == 1) || ($urandom_range(3) == 0);
      push_w = $urandom_range(45, 75);
      sent   = 0;
      while (sent < PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < push_w) begin
          if ($urandom_range(49) == 0) begin
            send_byte(model_push_op, 1'b1);
            sent += 1;
          end else begin
            send_push(BYTE_W'($urandom_range(255)), $urandom_range(19) == 0);
            sent += 2;
          end
        end else if (r < push_w + 20) begin
          send_byte(model_move_op, $urandom_range(19) == 0);
          sent += 1;
        end else begin
          send_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
          sent += 1;
        end
        // Pause mid-phase until every result is back
        if (sent >= PHASE_BYTES / 2 && sent < PHASE_BYTES / 2 + 2) wait_for_results();
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.code_byte   = '0;
    in_ch.program_end = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_PUSH_OPCODE;
    cfg_data_i        = '0;
    model_fill        = 0;
    model_mode        = MODE_OPCODE;
    model_push_op     = PUSH_OPCODE_RST;
    model_move_op     = MOVE_OPCODE_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_shared_opcode();
    test_stack_overflow(4);
    test_random_programs(5);

    wait_for_results();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/smd_pkg.sv
rtl/smd_if.sv
rtl/smd_core.sv
rtl/stack_bytecode_move_decoder.sv
tb/tb.sv
